// ----- rtl/acmt_pkg.sv -----
// Shared types, constants and AES round functions for the AES-CMAC tag block.
package acmt_pkg;

   localparam logic [7:0] CSR_KEY_HIGH = 8'd0;
   localparam logic [7:0] CSR_KEY_LOW  = 8'd1;
   localparam logic [7:0] PAD_BYTE     = 8'h80;
   localparam logic [7:0] RB_CONST     = 8'h87;
   localparam logic [3:0] LAST_ROUND   = 4'd10;

   typedef enum logic [1:0] {
      JOB_CHAIN,      // full block, more data follows
      JOB_CHAIN_ONE,  // full block chained, then a final block of one byte
      JOB_FIN_FULL,   // final block complete, use K1
      JOB_FIN_PART    // final block already padded, use K2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   tail_byte;
      logic [127:0] blk;
   } job_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits 127-8i
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            o[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3, all;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         o[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         o[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         o[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         o[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return o;
   endfunction

   function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
      logic [31:0] t, n0, n1, n2, n3;
      t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      n0 = rk[127:96] ^ t;
      n1 = rk[95:64] ^ n0;
      n2 = rk[63:32] ^ n1;
      n3 = rk[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   function automatic logic [127:0] cmac_double(input logic [127:0] v);
      cmac_double = {v[126:0], 1'b0} ^ (v[127] ? {120'd0, RB_CONST} : 128'd0);
   endfunction

endpackage

// ----- rtl/acmt_front.sv -----
// Front end: gathers message bytes into blocks and queues chain and final jobs.
module acmt_front
   import acmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic [7:0] buf_ff [16];
   logic [7:0] buf_in [16];
   logic [7:0] nb [16];
   logic [7:0] pad [16];
   logic [4:0] fill_ff, fill_in, n;
   logic       full, accept;

   function automatic logic [127:0] pack(input logic [7:0] b [16]);
      logic [127:0] o;
      o = '0;
      for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = b[i];
      return o;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign full       = fill_ff[4];
   assign n          = fill_ff + 5'(req_tuser);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         nb[i] = (req_tuser && !full && fill_ff[3:0] == 4'(i)) ? req_tdata : buf_ff[i];
         if (5'(i) < n) pad[i] = nb[i];
         else if (5'(i) == n) pad[i] = PAD_BYTE;
         else pad[i] = 8'h00;
      end
   end

   always_comb begin
      buf_in = buf_ff;
      fill_in = fill_ff;
      q_push = 1'b0;
      q_job.kind = JOB_CHAIN;
      q_job.tail_byte = req_tdata;
      q_job.blk = pack(buf_ff);
      if (accept) begin
         if (req_tuser && full) begin
            buf_in[0] = req_tdata;
            fill_in = 5'd1;
            q_push = 1'b1;
            if (req_tlast) begin
               q_job.kind = JOB_CHAIN_ONE;
               fill_in = 5'd0;
            end
         end else begin
            buf_in = nb;
            fill_in = n;
            if (req_tlast) begin
               q_push = 1'b1;
               fill_in = 5'd0;
               if (n[4]) begin
                  q_job.kind = JOB_FIN_FULL;
                  q_job.blk = pack(nb);
               end else begin
                  q_job.kind = JOB_FIN_PART;
                  q_job.blk = pack(pad);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         fill_ff <= 5'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// ----- rtl/acmt_fifo.sv -----
// Two-entry job queue between the front end and the AES back end.
module acmt_fifo
   import acmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_job
);

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign pop_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ----- rtl/acmt_aes.sv -----
// Round-iterative AES-128 encryption core, one round per cycle, key expanded on the fly.
module acmt_aes
   import acmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] din,
   input  logic [127:0] key,
   output logic         done,
   output logic [127:0] dout
);

   logic [127:0] state_ff, state_in, rk_ff, rk_in, rk_next, sr;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in, done_ff, done_in;

   assign rk_next = key_next(rk_ff, rcon_ff);
   assign sr      = sub_shift(state_ff);
   assign done    = done_ff;
   assign dout    = state_ff;

   always_comb begin
      state_in = state_ff;
      rk_in    = rk_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         state_in = din ^ key;
         rk_in    = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = ((round_ff == LAST_ROUND) ? sr : mix_cols(sr)) ^ rk_next;
         rk_in    = rk_next;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == LAST_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rk_ff    <= rk_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ----- rtl/acmt_back.sv -----
// Back end: derives subkeys, chains blocks through AES and registers the tag.
module acmt_back
   import acmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [127:0] key,
   input  logic         q_empty,
   input  job_type      q_job,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata
);

   typedef enum logic [2:0] {S_IDLE, S_DERIVE, S_MAIN, S_EXTRA, S_OUT} state_type;

   state_type    state_ff, state_in;
   job_type      job_ff, job_in;
   logic [127:0] x_ff, x_in, k1_ff, k1_in, k2_ff, k2_in, k1n, k2n;
   logic [127:0] rsp_data_ff, rsp_data_in, aes_din, aes_dout;
   logic         have_ff, have_in, rsp_valid_ff, rsp_valid_in, aes_start, aes_done;

   function automatic logic [127:0] operand(input job_type j, input logic [127:0] k1,
                                            input logic [127:0] k2);
      case (j.kind)
         JOB_FIN_FULL: operand = j.blk ^ k1;
         JOB_FIN_PART: operand = j.blk ^ k2;
         default:      operand = j.blk;
      endcase
   endfunction

   acmt_aes u_aes (
      .clock (clock),
      .reset (reset),
      .start (aes_start),
      .din   (aes_din),
      .key   (key),
      .done  (aes_done),
      .dout  (aes_dout)
   );

   assign k1n        = cmac_double(aes_dout);
   assign k2n        = cmac_double(k1n);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      x_in         = x_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      aes_start    = 1'b0;
      aes_din      = '0;
      q_pop        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               job_in    = q_job;
               aes_start = 1'b1;
               if (have_ff) begin
                  aes_din  = x_ff ^ operand(q_job, k1_ff, k2_ff);
                  state_in = S_MAIN;
               end else begin
                  state_in = S_DERIVE;
               end
            end
         end
         S_DERIVE: begin
            if (aes_done) begin
               k1_in     = k1n;
               k2_in     = k2n;
               have_in   = 1'b1;
               aes_start = 1'b1;
               aes_din   = x_ff ^ operand(job_ff, k1n, k2n);
               state_in  = S_MAIN;
            end
         end
         S_MAIN: begin
            if (aes_done) begin
               case (job_ff.kind)
                  JOB_CHAIN: begin
                     x_in     = aes_dout;
                     state_in = S_IDLE;
                  end
                  JOB_CHAIN_ONE: begin
                     x_in      = aes_dout;
                     aes_start = 1'b1;
                     aes_din   = aes_dout ^ k2_ff ^ {job_ff.tail_byte, PAD_BYTE, 112'd0};
                     state_in  = S_EXTRA;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_EXTRA: begin
            if (aes_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {aes_dout[63:0], aes_dout[127:64]};
               x_in         = '0;
               have_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         x_ff         <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/aes_cmac_tag.sv -----
// AES-CMAC (AES-128) tag engine over a byte stream, top level.
// Message bytes are taken one per cycle, while the job queue has room, into a 16-byte gather
// buffer; each completed block is queued (two entries) for a round-iterative AES core, and the
// back end pops the next queued block once the last pass ends, so a long message streams at
// one byte per cycle. The first block of each message adds one more AES pass for the subkeys,
// a final block that follows a full one adds another, and the tag leaves through an output
// register. The key must be written through the csr channel only while no message is in
// flight; the block itself does not enforce this.
module aes_cmac_tag
   import acmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // msg_byte
   input  logic         req_tuser,   // byte_valid
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // tag_high [63:0], tag_low [127:64]
);

   logic [63:0] key_high_ff, key_low_ff;
   logic        q_push, q_full, q_pop, q_empty;
   job_type     push_job, pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   acmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   acmt_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   acmt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .key        ({key_high_ff, key_low_ff}),
      .q_empty    (q_empty),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/acmt_checker.sv -----
// Port-level checks for the AES-CMAC tag engine and their binding to the top level.
module acmt_checker (
   input logic         clock,
   input logic         reset,
   input logic         csr_ready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp item right after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr channel not ready");

endmodule

bind aes_cmac_tag acmt_checker u_chk (.*);

// ----- tb/tb_aes_cmac_tag.sv -----
// Self-checking testbench for the AES-CMAC tag block: RFC 4493 vectors and directed endings, then random messages.
`timescale 1ns / 100ps

module tb_aes_cmac_tag
   import acmt_pkg::*;
;

   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 60;
   localparam int RAND_ITEMS  = 1000;
   localparam int DIR_ROWS    = 22;

   typedef struct packed {
      logic [7:0]   data;
      logic         valid;
      logic         last;
      logic         pinned;
      logic [127:0] tag;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // msg_byte
   logic         req_tuser = 1'b0; // byte_valid
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // tag_high [63:0], tag_low [127:64]

   aes_cmac_tag dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [63:0]  key_hi, key_lo;
   logic [127:0] sub_k1, sub_k2, chain;
   logic [7:0]   gather [16];
   int           fill;
   bit           keys_known;

   logic [127:0] tags_due [$];
   logic [127:0] pin_tag;
   bit           pin_on;
   int           errors, tags_seen, msgs_sent, idle_cycles, rsp_stall;
   bit           rsp_calm;

   function automatic logic [7:0] mul_x(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes128(input logic [127:0] k, input logic [127:0] pt);
      logic [7:0] rk [176];
      logic [7:0] st [16];
      logic [7:0] sb [16];
      logic [7:0] t [4];
      logic [7:0] rc, f, a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) rk[i] = k[127 - 8 * i -: 8];
      rc = 8'h01;
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
         if (i % 16 == 0) begin
            f = t[0];
            t[0] = SBOX[t[1]] ^ rc;
            t[1] = SBOX[t[2]];
            t[2] = SBOX[t[3]];
            t[3] = SBOX[f];
            rc = mul_x(rc);
         end
         for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ t[j];
      end
      for (int i = 0; i < 16; i++) st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) sb[r + 4 * c] = SBOX[st[r + 4 * ((c + r) % 4)]];
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = sb[4 * c];
               a1 = sb[4 * c + 1];
               a2 = sb[4 * c + 2];
               a3 = sb[4 * c + 3];
               al = a0 ^ a1 ^ a2 ^ a3;
               sb[4 * c]     = a0 ^ al ^ mul_x(a0 ^ a1);
               sb[4 * c + 1] = a1 ^ al ^ mul_x(a1 ^ a2);
               sb[4 * c + 2] = a2 ^ al ^ mul_x(a2 ^ a3);
               sb[4 * c + 3] = a3 ^ al ^ mul_x(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = sb[i] ^ rk[16 * rnd + i];
      end
      for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = st[i];
      return o;
   endfunction

   function automatic logic [127:0] shift_gf(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
   endfunction

   function automatic logic [127:0] gather_block();
      logic [127:0] o;
      for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = gather[i];
      return o;
   endfunction

   // advances the model by one item; returns 1 with the tag when the message ends
   function automatic bit tag_step(input logic [7:0] b, input bit v, input bit l,
                                   output logic [127:0] tag);
      logic [127:0] fin;
      tag = '0;
      if (!keys_known) begin
         sub_k1 = shift_gf(aes128({key_hi, key_lo}, 128'h0));
         sub_k2 = shift_gf(sub_k1);
         chain = '0;
         fill = 0;
         keys_known = 1'b1;
      end
      if (v) begin
         if (fill >= 16) begin
            chain = aes128({key_hi, key_lo}, chain ^ gather_block());
            fill = 0;
         end
         gather[fill] = b;
         fill++;
      end
      if (!l) return 1'b0;
      if (fill >= 16) begin
         fin = gather_block() ^ sub_k1;
      end else begin
         fin = '0;
         for (int i = 0; i < fill; i++) fin[127 - 8 * i -: 8] = gather[i];
         fin[127 - 8 * fill -: 8] = PAD_BYTE;
         fin ^= sub_k2;
      end
      tag = aes128({key_hi, key_lo}, chain ^ fin);
      chain = '0;
      fill = 0;
      keys_known = 1'b0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      logic [127:0] exp_tag, new_tag;
      if (reset) begin
         key_hi = '0;
         key_lo = '0;
         sub_k1 = '0;
         sub_k2 = '0;
         chain = '0;
         fill = 0;
         keys_known = 1'b0;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            tags_seen++;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
            if (tags_due.size() == 0) begin
               $error("tag item with none expected: %h", rsp_tdata);
               errors++;
            end else begin
               exp_tag = tags_due.pop_front();
               if (rsp_tdata[63:0] !== exp_tag[127:64]) begin
                  $error("tag_high expected %h actual %h", exp_tag[127:64], rsp_tdata[63:0]);
                  errors++;
               end
               if (rsp_tdata[127:64] !== exp_tag[63:0]) begin
                  $error("tag_low expected %h actual %h", exp_tag[63:0], rsp_tdata[127:64]);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            idle_cycles = 0;
            if (csr_index == CSR_KEY_HIGH) key_hi = csr_data;
            else if (csr_index == CSR_KEY_LOW) key_lo = csr_data;
         end
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            if (tag_step(req_tdata, req_tuser, req_tlast, new_tag))
               tags_due.push_back(pin_on ? pin_tag : new_tag);
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= !reset;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [7:0] b, input bit v, input bit l, input bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= v;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after its last write
   task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tags_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
      drain();
      write_reg(CSR_KEY_HIGH, hi);
      write_reg(CSR_KEY_LOW, lo);
      csr_valid <= 1'b0;
   endtask

   initial begin
      dir_row_type rows [DIR_ROWS];
      logic [7:0] rfc_msg [16];
      int items, len, pick;
      bit calm;
      rfc_msg = '{8'h6b, 8'hc1, 8'hbe, 8'he2, 8'h2e, 8'h40, 8'h9f, 8'h96,
                  8'he9, 8'h3d, 8'h7e, 8'h11, 8'h73, 8'h93, 8'h17, 8'h2a};
      rows[0] = '{8'h00, 1'b0, 1'b1, 1'b1, 128'hbb1d6929e95937287fa37d129b756746};
      for (int i = 0; i < 16; i++)
         rows[1 + i] = '{rfc_msg[i], 1'b1, i == 15, i == 15,
                         128'h070a16b46b4d4144f79bdd9dd04a287c};
      rows[17] = '{8'h00, 1'b0, 1'b0, 1'b0, 128'h0};  // ignored item opens a message
      rows[18] = '{8'hff, 1'b1, 1'b0, 1'b0, 128'h0};
      rows[19] = '{8'h00, 1'b1, 1'b0, 1'b0, 128'h0};
      rows[20] = '{8'h5a, 1'b0, 1'b1, 1'b0, 128'h0};  // ends on bytes already held
      rows[21] = '{8'hff, 1'b1, 1'b1, 1'b0, 128'h0};
      errors = 0;
      tags_seen = 0;
      msgs_sent = 0;
      rsp_stall = 0;
      rsp_calm = 1'b0;
      pin_on = 1'b0;
      pin_tag = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      for (int i = 0; i < DIR_ROWS; i++) begin
         pin_on = rows[i].pinned;
         pin_tag = rows[i].tag;
         send_item(rows[i].data, rows[i].valid, rows[i].last, i % 3 == 0);
         if (rows[i].last) msgs_sent++;
      end
      drain();
      pin_on = 1'b0;

      items = 0;
      while (items < RAND_ITEMS) begin
         if (msgs_sent % 12 == 0) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) load_key('0, '0);
            else if (pick == 1) load_key('1, '1);
            else load_key({$urandom, $urandom}, {$urandom, $urandom});
         end
         calm = $urandom_range(0, 3) == 0;
         pick = $urandom_range(0, 9);
         if (pick < 2) len = 0;
         else if (pick < 4) len = 16 * $urandom_range(1, 3);
         else len = $urandom_range(1, 40);
         if (len == 0) begin
            send_item($urandom, 1'b0, 1'b1, calm);
         end else begin
            bit tail_empty;
            tail_empty = $urandom_range(0, 4) == 0;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 19) == 0) send_item($urandom, 1'b0, 1'b0, calm);
               send_item($urandom, 1'b1, !tail_empty && i == len - 1, calm);
               items++;
            end
            if (tail_empty) send_item($urandom, 1'b0, 1'b1, calm);
         end
         items++;
         msgs_sent++;
      end
      drain();
      $display("ran %0d messages under several keys, %0d tags returned", msgs_sent, tags_seen);
      $display("covered empty, block-aligned, ragged and byte-less-last endings");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
